// File: hdl/assert_macros.svh
// Assertion macros used by the top-level clustering module.
// Defined empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("fail");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("fail");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: hdl/rfec_pkg.sv
// Shared constants and types of the range-filtered clustering block.
// No dependencies.
package rfec_pkg;
  localparam int unsigned MaxPointsDef = 1024;
  localparam int unsigned CfgLatMin = 0;
  localparam int unsigned CfgLatMax = 1;
  localparam int unsigned CfgFwdMax = 2;
  localparam int unsigned CfgRadius = 3;
  localparam logic OpLoad = 1'b0;
  localparam logic OpRead = 1'b1;

  // One classified command handed from the front to the back.
  typedef struct packed {
    logic              is_read;
    logic              keep;
    logic              frame_end;
    logic signed [15:0] lat;
    logic signed [15:0] fwd;
    logic signed [15:0] hgt;
  } rfec_cmd_t;
endpackage

// File: hdl/rfec_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module rfec_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/rfec_front.sv
// Front: accepts input items and applies the range filter.
// Depends on rfec_pkg.
module rfec_front
  import rfec_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic signed [15:0] in_lateral_mm,
  input  logic signed [15:0] in_forward_mm,
  input  logic signed [15:0] in_height_mm,
  input  logic               in_frame_end,
  input  logic signed [15:0] lat_min_r,
  input  logic signed [15:0] lat_max_r,
  input  logic [14:0]        fwd_max_r,
  output logic               q_valid,
  input  logic               q_ready,
  output rfec_cmd_t          q_cmd
);
  // Two-entry queue toward the back.
  rfec_cmd_t buf_r [2];
  logic [1:0] cnt_r;
  logic       rd_r, wr_r;
  logic       push, pop;
  rfec_cmd_t  cmd;

  always_comb begin
    cmd.is_read   = (in_op == OpRead);
    cmd.frame_end = in_frame_end;
    cmd.lat       = in_lateral_mm;
    cmd.fwd       = in_forward_mm;
    cmd.hgt       = in_height_mm;
    cmd.keep = (in_forward_mm > 16'sd0)
            && (in_forward_mm <= $signed({1'b0, fwd_max_r}))
            && (in_lateral_mm >= lat_min_r) && (in_lateral_mm <= lat_max_r);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = buf_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (push) begin
        buf_r[wr_r] <= cmd;
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: hdl/rfec_back.sv
// Back: stores points, grows clusters breadth-first, returns results.
// Depends on rfec_pkg and rfec_ram.
module rfec_back
  import rfec_pkg::*;
#(
  parameter int unsigned MaxPoints = MaxPointsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  rfec_cmd_t          q_cmd,
  input  logic [29:0]        radius_r,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_result_valid,
  output logic [15:0]        out_source_index,
  output logic signed [15:0] out_out_lateral_mm,
  output logic signed [15:0] out_out_forward_mm,
  output logic signed [15:0] out_out_height_mm,
  output logic [9:0]         out_cluster_id,
  output logic               out_cluster_last,
  output logic               out_results_last,
  output logic               out_overflowed,
  output logic               busy
);
  localparam int unsigned AW = $clog2(MaxPoints);
  localparam int unsigned CW = $clog2(MaxPoints + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MaxPoints);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_SEED, S_SEED_CHK, S_CLAIM, S_CENTER, S_CENTER_W,
    S_SCAN, S_SCAN_W, S_SCAN_CHK, S_READ_W, S_READ_OUT
  } state_t;

  state_t st_r;
  logic [CW-1:0] kept_r, tail_r, head_r, seed_r, k_r, rp_r, clr_r;
  logic [15:0]   raw_r;
  logic [9:0]    cid_r;
  logic          ovf_r, reading_r;
  logic signed [15:0] cx_r, cy_r;
  logic [31:0]   dx2_r, dy2_r;
  logic          kclaimed_r;

  // Memories: points with raw index, the visit order with end marks, claim flags.
  logic          pt_we;
  logic [AW-1:0] pt_wa, pt_ra;
  logic [63:0]   pt_wd, pt_rd;
  logic          ord_we;
  logic [AW-1:0] ord_wa, ord_ra;
  logic [AW:0]   ord_wd, ord_rd;
  logic          cl_we;
  logic [AW-1:0] cl_wa, cl_ra;
  logic [0:0]    cl_wd, cl_rd;

  rfec_ram #(.Width(64), .Depth(MaxPoints)) u_pts (
    .clk, .we(pt_we), .waddr(pt_wa), .wdata(pt_wd), .raddr(pt_ra), .rdata(pt_rd));
  rfec_ram #(.Width(AW + 1), .Depth(MaxPoints)) u_ord (
    .clk, .we(ord_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata(ord_rd));
  rfec_ram #(.Width(1), .Depth(MaxPoints)) u_clm (
    .clk, .we(cl_we), .waddr(cl_wa), .wdata(cl_wd), .raddr(cl_ra), .rdata(cl_rd));

  wire signed [15:0] pr_lat = pt_rd[63:48];
  wire signed [15:0] pr_fwd = pt_rd[47:32];
  wire signed [15:0] pr_hgt = pt_rd[31:16];
  wire signed [16:0] dx = 17'(pr_lat) - 17'(cx_r);
  wire signed [16:0] dy = 17'(pr_fwd) - 17'(cy_r);
  wire [32:0] dsum = 33'(dx2_r) + 33'(dy2_r);

  assign q_ready = (st_r == S_IDLE) && !out_valid && (clr_r == '0);
  assign busy = (st_r != S_IDLE);

  wire take = q_valid && q_ready;
  wire fresh = take && !q_cmd.is_read && reading_r;
  wire [CW-1:0] kept_eff = fresh ? '0 : kept_r;
  wire store = take && !q_cmd.is_read && q_cmd.keep && (kept_eff < MaxCnt);

  // Memory addressing. A scan addresses the next point and its claim flag in the
  // preceding state, so both arrive together in S_SCAN_W.
  always_comb begin
    pt_we  = store;
    pt_wa  = kept_eff[AW-1:0];
    pt_wd  = {q_cmd.lat, q_cmd.fwd, q_cmd.hgt, fresh ? 16'd0 : raw_r};
    pt_ra  = k_r[AW-1:0];
    ord_we = 1'b0;
    ord_wa = tail_r[AW-1:0];
    ord_wd = {1'b0, seed_r[AW-1:0]};
    ord_ra = head_r[AW-1:0];
    cl_we  = 1'b0;
    cl_wa  = seed_r[AW-1:0];
    cl_wd  = 1'b1;
    unique case (st_r)
      S_IDLE: ord_ra = rp_r[AW-1:0];
      S_CLEAR: begin
        cl_we = 1'b1;
        cl_wa = clr_r[AW-1:0];
        cl_wd = 1'b0;
      end
      S_SEED_CHK: if (seed_r < kept_r && !cl_rd[0] && tail_r != '0) begin
        ord_we = 1'b1;
        ord_wa = AW'(tail_r - 1'b1);
        ord_wd = {1'b1, ord_rd[AW-1:0]};
      end
      S_CLAIM: begin
        ord_we = 1'b1;
        cl_we  = 1'b1;
      end
      S_CENTER: ord_ra = head_r[AW-1:0];
      S_CENTER_W: pt_ra = ord_rd[AW-1:0];
      S_SCAN_CHK: begin
        pt_ra = AW'(k_r + 1'b1);
        if (!kclaimed_r && dsum <= 33'(radius_r)) begin
          ord_we = 1'b1;
          ord_wd = {1'b0, k_r[AW-1:0]};
          cl_we  = 1'b1;
          cl_wa  = k_r[AW-1:0];
        end
      end
      S_READ_W: begin
        ord_ra = rp_r[AW-1:0];
        pt_ra  = ord_rd[AW-1:0];
      end
      default: ;
    endcase
    if (st_r == S_SEED || st_r == S_SEED_CHK) ord_ra = AW'(tail_r - 1'b1);
    cl_ra = (st_r == S_SEED) ? seed_r[AW-1:0] : pt_ra;
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; kept_r <= '0; raw_r <= '0; ovf_r <= 1'b0; reading_r <= 1'b0;
      rp_r <= '0; cid_r <= '0; out_valid <= 1'b0; clr_r <= '0;
      tail_r <= '0; head_r <= '0; seed_r <= '0; k_r <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: if (take) begin
          if (q_cmd.is_read) begin
            out_overflowed <= ovf_r;
            if (reading_r && rp_r < kept_r) st_r <= S_READ_W;
            else begin
              out_valid <= 1'b1; out_result_valid <= 1'b0;
              out_source_index <= '0; out_out_lateral_mm <= '0;
              out_out_forward_mm <= '0; out_out_height_mm <= '0;
              out_cluster_id <= '0; out_cluster_last <= 1'b0;
              out_results_last <= 1'b0;
            end
          end else begin
            if (fresh) begin
              reading_r <= 1'b0; ovf_r <= 1'b0; rp_r <= '0; cid_r <= '0;
            end
            kept_r <= kept_eff + CW'(store);
            if (!store && q_cmd.keep && !(kept_eff < MaxCnt)) ovf_r <= 1'b1;
            raw_r <= (fresh ? 16'd0 : raw_r) + 16'd1;
            if (q_cmd.frame_end) begin
              tail_r <= '0; seed_r <= '0; st_r <= S_CLEAR;
            end
          end
        end
        // Clear the claim flags of every stored point, one per cycle.
        S_CLEAR: begin
          if (clr_r + 1'b1 >= kept_r) begin
            clr_r <= '0; st_r <= S_SEED;
          end else begin
            clr_r <= clr_r + 1'b1;
          end
        end
        S_SEED: st_r <= S_SEED_CHK;
        S_SEED_CHK: begin
          if (seed_r >= kept_r) begin
            st_r <= S_IDLE; reading_r <= 1'b1; rp_r <= '0; cid_r <= '0;
          end else if (cl_rd[0]) begin
            seed_r <= seed_r + 1'b1; st_r <= S_SEED;
          end else begin
            st_r <= S_CLAIM;
          end
        end
        S_CLAIM: begin
          head_r <= tail_r; tail_r <= tail_r + 1'b1; st_r <= S_CENTER;
        end
        S_CENTER: begin
          if (head_r == tail_r) st_r <= S_SEED;
          else st_r <= S_CENTER_W;
        end
        S_CENTER_W: begin
          k_r <= '0; head_r <= head_r + 1'b1; st_r <= S_SCAN;
        end
        S_SCAN: begin
          cx_r <= pr_lat; cy_r <= pr_fwd; st_r <= S_SCAN_W;
        end
        S_SCAN_W: begin
          dx2_r <= 32'($signed(dx) * $signed(dx));
          dy2_r <= 32'($signed(dy) * $signed(dy));
          kclaimed_r <= cl_rd[0];
          st_r <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (!kclaimed_r && dsum <= 33'(radius_r)) begin
            tail_r <= tail_r + 1'b1;
          end
          if (k_r + 1'b1 >= kept_r) st_r <= S_CENTER;
          else begin
            k_r <= k_r + 1'b1; st_r <= S_SCAN_W;
          end
        end
        S_READ_W: st_r <= S_READ_OUT;
        S_READ_OUT: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
      // The last cluster carries no end mark; it ends at the last stored point.
      if (st_r == S_READ_OUT) begin
        out_valid <= 1'b1; out_result_valid <= 1'b1;
        out_source_index <= pt_rd[15:0];
        out_out_lateral_mm <= pr_lat; out_out_forward_mm <= pr_fwd;
        out_out_height_mm <= pr_hgt; out_cluster_id <= cid_r;
        out_cluster_last <= ord_rd[AW] || (rp_r + 1'b1 == kept_r);
        out_results_last <= (rp_r + 1'b1 == kept_r);
        rp_r <= rp_r + 1'b1;
        if (ord_rd[AW] || (rp_r + 1'b1 == kept_r)) cid_r <= cid_r + 10'd1;
      end
    end
  end
endmodule

// File: hdl/range_filtered_euclidean_clustering.sv
// Range-filtered Euclidean clustering: loads stream at one point per cycle while the
// back is idle. The frame-end point starts a clearing pass over the claim flags of
// the N stored points, then clustering, where every point serves once as a center
// and each compare against the point RAM runs through S_SCAN_W and S_SCAN_CHK. A read
// returns its beat via S_READ_W, S_READ_OUT (from S_IDLE if none is left); later items wait.
// Synchronous active-low reset restores register defaults and clears state.
module range_filtered_euclidean_clustering
  import rfec_pkg::*;
#(
  parameter int unsigned MaxPoints = MaxPointsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [29:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic signed [15:0] in_lateral_mm,
  input  logic signed [15:0] in_forward_mm,
  input  logic signed [15:0] in_height_mm,
  input  logic               in_frame_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_result_valid,
  output logic [15:0]        out_source_index,
  output logic signed [15:0] out_out_lateral_mm,
  output logic signed [15:0] out_out_forward_mm,
  output logic signed [15:0] out_out_height_mm,
  output logic [9:0]         out_cluster_id,
  output logic               out_cluster_last,
  output logic               out_results_last,
  output logic               out_overflowed
);
`include "assert_macros.svh"
  logic signed [15:0] lat_min_r, lat_max_r;
  logic [14:0] fwd_max_r;
  logic [29:0] radius_r;
  logic q_valid, q_ready, busy;
  rfec_cmd_t q_cmd;

  // Configuration registers; writes wait while the back is busy clearing, clustering or reading.
  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_min_r <= -16'sd6000; lat_max_r <= 16'sd6000;
      fwd_max_r <= 15'd6000; radius_r <= 30'd40000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        2'(CfgLatMin): lat_min_r <= cfg_data[15:0];
        2'(CfgLatMax): lat_max_r <= cfg_data[15:0];
        2'(CfgFwdMax): fwd_max_r <= cfg_data[14:0];
        2'(CfgRadius): radius_r <= cfg_data;
        default: ;
      endcase
    end
  end

  rfec_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .in_lateral_mm, .in_forward_mm,
    .in_height_mm, .in_frame_end, .lat_min_r, .lat_max_r, .fwd_max_r,
    .q_valid, .q_ready, .q_cmd);

  rfec_back #(.MaxPoints(MaxPoints)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd, .radius_r, .out_valid, .out_ready,
    .out_result_valid, .out_source_index, .out_out_lateral_mm, .out_out_forward_mm,
    .out_out_height_mm, .out_cluster_id, .out_cluster_last, .out_results_last,
    .out_overflowed, .busy);

  `ASSERT_IMPLIES(a_last_ends_cluster, clk, rst_n, out_valid && out_results_last, out_cluster_last)
  `ASSERT_IMPLIES(a_empty_clean, clk, rst_n, out_valid && !out_result_valid, !out_cluster_last)
  `ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule
